/* rtl/lsq_pkg.sv */
// Shared types, constants and helpers for the load/store queue forwarding block.
package lsq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TagWidthDef   = 6;
  localparam int unsigned SlotW         = 4;
  localparam int unsigned CountW        = 5;
  localparam int unsigned OutTagW       = 6;

  typedef enum logic [2:0] {
    OP_LB  = 3'd0,
    OP_LBU = 3'd1,
    OP_LH  = 3'd2,
    OP_LHU = 3'd3,
    OP_LW  = 3'd4,
    OP_SB  = 3'd5,
    OP_SH  = 3'd6,
    OP_SW  = 3'd7
  } mem_op_e;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [2:0]  mem_op;
    logic [5:0]  tag;
    logic [31:0] offset;
    logic [31:0] base_value;
    logic        base_ready;
    logic [31:0] store_value;
    logic        store_ready;
    logic [4:0]  entry_count;
    logic        bus_busy;
  } lsq_req_t;

  typedef struct packed {
    logic        forward_valid;
    logic [5:0]  forward_tag;
    logic [31:0] forward_data;
  } lsq_rsp_t;

  function automatic logic op_is_load(logic [2:0] op);
    return op <= OP_LW;
  endfunction

  function automatic logic op_is_store(logic [2:0] op);
    return op >= OP_SB;
  endfunction

  function automatic logic [31:0] convert_value(logic [2:0] ld, logic [2:0] st,
                                                logic [31:0] data);
    logic [31:0] v;
    v = data;
    if (st == OP_SB) v = v & 32'h0000_00FF;
    if (st == OP_SH) v = v & 32'h0000_FFFF;
    case (ld)
      OP_LB:   v = {{24{v[7]}}, v[7:0]};
      OP_LBU:  v = {24'd0, v[7:0]};
      OP_LH:   v = {{16{v[15]}}, v[15:0]};
      OP_LHU:  v = {16'd0, v[15:0]};
      default: v = v;
    endcase
    return v;
  endfunction

endpackage

/* rtl/lsq_cell.sv */
// One queue slot: holds the entry and compares a passing load address against it.
module lsq_cell import lsq_pkg::*; #(
  parameter int unsigned TagWidth = TagWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  logic [2:0]          op_i,
  input  logic [TagWidth-1:0] tag_i,
  input  logic [31:0]         offset_i,
  input  logic [31:0]         base_i,
  input  logic                base_ready_i,
  input  logic [31:0]         store_data_i,
  input  logic                store_ready_i,
  input  logic                agen_i,
  // search probe passed along the chain toward higher slots
  input  logic                srch_act_i,
  input  logic [31:0]         srch_addr_i,
  input  logic                srch_hit_i,
  input  logic [2:0]          srch_st_op_i,
  input  logic [31:0]         srch_st_data_i,
  output logic                srch_hit_o,
  output logic [2:0]          srch_st_op_o,
  output logic [31:0]         srch_st_data_o,
  output logic                agen_ready_o,
  output logic                known_o,
  output logic [2:0]          op_o,
  output logic [TagWidth-1:0] tag_o,
  output logic [31:0]         addr_o
);

  logic [2:0]          op_q;
  logic [TagWidth-1:0] tag_q;
  logic [31:0]         off_q, base_q, sdata_q, addr_q;
  logic                bready_q, sready_q, known_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bready_q <= 1'b0;
      sready_q <= 1'b0;
      known_q  <= 1'b0;
    end else if (wr_i) begin
      bready_q <= base_ready_i;
      sready_q <= store_ready_i;
      known_q  <= 1'b0;
    end else if (agen_i) begin
      known_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      op_q    <= op_i;
      tag_q   <= tag_i;
      off_q   <= offset_i;
      base_q  <= base_i;
      sdata_q <= store_data_i;
    end
    if (agen_i) addr_q <= off_q + base_q;
  end

  // the nearest older matching store wins, so a later cell overrides
  logic match;
  assign match = srch_act_i && known_q && op_is_store(op_q) && sready_q &&
                 addr_q == srch_addr_i;
  assign srch_hit_o     = srch_hit_i | match;
  assign srch_st_op_o   = match ? op_q : srch_st_op_i;
  assign srch_st_data_o = match ? sdata_q : srch_st_data_i;

  assign agen_ready_o = bready_q && sready_q && !known_q;
  assign known_o      = known_q;
  assign op_o         = op_q;
  assign tag_o        = tag_q;
  assign addr_o       = addr_q;

endmodule

/* rtl/lsq_address_gen_store_forward_core.sv */
// Top level of the load/store queue address generation and forwarding block.
// Usage:
//   req channel (req_valid_i/req_ready_o/req_i) carries write and tick requests.
//   rsp channel (rsp_valid_o/rsp_ready_i/rsp_o) returns one result per request.
//   A write request fills one slot and answers with an all-zero result.
//   A tick request generates at most one address, then walks loads in slot
//   order; for load slot i the store probe is passed through slots 0..i-1,
//   one slot per cycle. A tick with the bus busy answers with an all-zero
//   result after address generation and walks no loads; the walk ends at
//   the first hit, at the first slot whose address is not known, or at count.
//   Reset clears all ready and address-known flags; slot contents stay
//   undefined until written. A stalled receiver holds the result in the output
//   register and the block takes no new request until it is taken.
module lsq_address_gen_store_forward_core import lsq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TAG_WIDTH   = TagWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  lsq_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output lsq_rsp_t rsp_o
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_AGEN, S_SCAN, S_PROBE} state_e;

  state_e          state_q;
  lsq_req_t        req_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW:0]   ld_q, pr_q;    // current load slot, probe position
  logic            hit_q;
  logic [2:0]      sop_q;
  logic [31:0]     sdata_q;
  logic            rsp_valid_q;
  lsq_rsp_t        rsp_q;

  logic [QUEUE_DEPTH-1:0] wr, agen, agen_rdy, known, hit_o;
  logic [2:0]             op_a[QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0]   tag_a[QUEUE_DEPTH];
  logic [31:0]            addr_a[QUEUE_DEPTH];
  logic [2:0]             sop_a[QUEUE_DEPTH];
  logic [31:0]            sd_a[QUEUE_DEPTH];

  logic [TAG_WIDTH-1:0] tag_in;
  always_comb begin
    tag_in = '0;
    for (int b = 0; b < TAG_WIDTH && b < 6; b++) tag_in[b] = req_i.tag[b];
  end

  logic accept;
  assign accept = req_valid_i && req_ready_o;

  // lowest ready slot below count gets its address
  logic [QUEUE_DEPTH-1:0] agen_sel;
  always_comb begin
    logic found;
    found = 1'b0;
    agen_sel = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (!found && agen_rdy[k] && k < int'(cnt_q)) begin
        agen_sel[k] = 1'b1;
        found = 1'b1;
      end
    end
  end

  logic [IdxW-1:0] ld_idx, pr_idx;
  assign ld_idx = ld_q[IdxW-1:0];
  assign pr_idx = pr_q[IdxW-1:0];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic act;
    assign wr[g]   = accept && req_i.kind == KIND_WRITE &&
                     {1'b0, req_i.slot} == (SlotW+1)'(g);
    assign agen[g] = (state_q == S_AGEN) && agen_sel[g];
    assign act     = (state_q == S_PROBE) && pr_q == (IdxW+1)'(g);
    if (g == 0) begin : g_head
      lsq_cell #(.TagWidth(TAG_WIDTH)) u_cell (
        .clk_i, .rst_ni, .wr_i(wr[g]), .op_i(req_i.mem_op), .tag_i(tag_in),
        .offset_i(req_i.offset), .base_i(req_i.base_value),
        .base_ready_i(req_i.base_ready), .store_data_i(req_i.store_value),
        .store_ready_i(req_i.store_ready), .agen_i(agen[g]),
        .srch_act_i(act), .srch_addr_i(addr_a[ld_idx]),
        .srch_hit_i(hit_q), .srch_st_op_i(sop_q), .srch_st_data_i(sdata_q),
        .srch_hit_o(hit_o[g]), .srch_st_op_o(sop_a[g]), .srch_st_data_o(sd_a[g]),
        .agen_ready_o(agen_rdy[g]), .known_o(known[g]), .op_o(op_a[g]),
        .tag_o(tag_a[g]), .addr_o(addr_a[g]));
    end else begin : g_body
      lsq_cell #(.TagWidth(TAG_WIDTH)) u_cell (
        .clk_i, .rst_ni, .wr_i(wr[g]), .op_i(req_i.mem_op), .tag_i(tag_in),
        .offset_i(req_i.offset), .base_i(req_i.base_value),
        .base_ready_i(req_i.base_ready), .store_data_i(req_i.store_value),
        .store_ready_i(req_i.store_ready), .agen_i(agen[g]),
        .srch_act_i(act), .srch_addr_i(addr_a[ld_idx]),
        .srch_hit_i(hit_o[g-1]), .srch_st_op_i(sop_a[g-1]),
        .srch_st_data_i(sd_a[g-1]),
        .srch_hit_o(hit_o[g]), .srch_st_op_o(sop_a[g]), .srch_st_data_o(sd_a[g]),
        .agen_ready_o(agen_rdy[g]), .known_o(known[g]), .op_o(op_a[g]),
        .tag_o(tag_a[g]), .addr_o(addr_a[g]));
    end
  end

  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;

  logic [CntW-1:0] cnt_sat;
  always_comb begin
    if (32'(req_i.entry_count) > QUEUE_DEPTH) cnt_sat = CntW'(QUEUE_DEPTH);
    else if (CntW >= CountW) cnt_sat = CntW'(req_i.entry_count);
    else cnt_sat = req_i.entry_count[CntW-1:0];
  end

  lsq_rsp_t fwd;
  always_comb begin
    fwd = '0;
    fwd.forward_valid = 1'b1;
    for (int b = 0; b < OutTagW && b < TAG_WIDTH; b++) fwd.forward_tag[b] = tag_a[ld_idx][b];
    fwd.forward_data = convert_value(op_a[ld_idx], sop_a[pr_idx], sd_a[pr_idx]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      cnt_q       <= '0;
      ld_q        <= '0;
      pr_q        <= '0;
      hit_q       <= 1'b0;
      sop_q       <= OP_SW;
      sdata_q     <= '0;
      req_q       <= '0;
      rsp_q       <= '0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q <= req_i;
            cnt_q <= cnt_sat;
            if (req_i.kind == KIND_WRITE) begin
              rsp_q       <= '0;
              rsp_valid_q <= 1'b1;
            end else begin
              state_q <= S_AGEN;
            end
          end
        end
        S_AGEN: begin
          ld_q <= '0;
          if (req_q.bus_busy) begin
            rsp_q       <= '0;
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ld_q >= (IdxW+1)'(cnt_q) || !known[ld_idx]) begin
            rsp_q       <= '0;
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (op_is_load(op_a[ld_idx]) && ld_q != '0) begin
            pr_q    <= '0;
            hit_q   <= 1'b0;
            state_q <= S_PROBE;
          end else begin
            ld_q <= ld_q + 1'b1;
          end
        end
        S_PROBE: begin
          hit_q   <= hit_o[pr_idx];
          sop_q   <= sop_a[pr_idx];
          sdata_q <= sd_a[pr_idx];
          if (pr_q + 1'b1 == ld_q) begin
            if (hit_o[pr_idx]) begin
              rsp_q       <= fwd;
              rsp_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              ld_q    <= ld_q + 1'b1;
              state_q <= S_SCAN;
            end
          end else begin
            pr_q <= pr_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* tb/sv/lsq_address_gen_store_forward_core_tb.sv */
// Testbench for the load/store queue address generation and forwarding block.
`timescale 1ns / 100ps

module lsq_address_gen_store_forward_core_tb;
  import lsq_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned NumItems  = 1500;

  // Predicts the response of each request and checks what the block returns.
  class lsq_scoreboard;
    mem_op_e     op_q[Depth];
    logic [5:0]  tag_q[Depth];
    logic [31:0] offs_q[Depth];
    logic [31:0] base_q[Depth];
    logic [31:0] sdata_q[Depth];
    logic [31:0] addr_q[Depth];
    bit          bready_q[Depth];
    bit          sready_q[Depth];
    bit          known_q[Depth];
    lsq_rsp_t    pending_rsp[$];
    int          errors;

    function new();
      errors = 0;
      for (int i = 0; i < Depth; i++) begin
        op_q[i] = OP_LB;
        tag_q[i] = '0;
        offs_q[i] = '0;
        base_q[i] = '0;
        sdata_q[i] = '0;
        addr_q[i] = '0;
        bready_q[i] = 0;
        sready_q[i] = 0;
        known_q[i] = 0;
      end
    endfunction

    function logic [31:0] load_result(mem_op_e ld, mem_op_e st, logic [31:0] data);
      logic [31:0] v;
      v = data;
      if (st == OP_SB) v[31:8] = '0;
      if (st == OP_SH) v[31:16] = '0;
      case (ld)
        OP_LB:   v = {{24{v[7]}}, v[7:0]};
        OP_LBU:  v = {24'd0, v[7:0]};
        OP_LH:   v = {{16{v[15]}}, v[15:0]};
        OP_LHU:  v = {16'd0, v[15:0]};
        default: v = v;
      endcase
      return v;
    endfunction

    function void note_request(lsq_req_t r);
      lsq_rsp_t e;
      int       cnt;
      bit       hit;
      e = '0;
      hit = 0;
      if (r.kind == KIND_WRITE) begin
        op_q[r.slot] = mem_op_e'(r.mem_op);
        tag_q[r.slot] = r.tag;
        offs_q[r.slot] = r.offset;
        base_q[r.slot] = r.base_value;
        bready_q[r.slot] = r.base_ready;
        sdata_q[r.slot] = r.store_value;
        sready_q[r.slot] = r.store_ready;
        known_q[r.slot] = 0;
      end else begin
        cnt = (r.entry_count > Depth) ? Depth : r.entry_count;
        for (int i = 0; i < cnt; i++) begin
          if (bready_q[i] && sready_q[i] && !known_q[i]) begin
            addr_q[i] = offs_q[i] + base_q[i];
            known_q[i] = 1;
            break;
          end
        end
        if (!r.bus_busy) begin
          for (int i = 0; i < cnt && !hit; i++) begin
            if (!known_q[i]) break;
            if (op_q[i] <= OP_LW) begin
              for (int j = i - 1; j >= 0 && !hit; j--) begin
                if (addr_q[j] == addr_q[i] && op_q[j] >= OP_SB && sready_q[j]) begin
                  hit = 1;
                  e.forward_valid = 1'b1;
                  e.forward_tag = tag_q[i];
                  e.forward_data = load_result(op_q[i], op_q[j], sdata_q[j]);
                end
              end
            end
          end
        end
      end
      pending_rsp.push_back(e);
    endfunction

    function void check_response(lsq_rsp_t a);
      lsq_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("unexpected response %h", a);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (a.forward_valid !== e.forward_valid) begin
        $error("forward_valid: expected %0d, got %0d", e.forward_valid, a.forward_valid);
        errors++;
      end
      if (a.forward_tag !== e.forward_tag) begin
        $error("forward_tag: expected %0d, got %0d", e.forward_tag, a.forward_tag);
        errors++;
      end
      if (a.forward_data !== e.forward_data) begin
        $error("forward_data: expected %h, got %h", e.forward_data, a.forward_data);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     req_valid_i;
  logic     req_ready_o;
  lsq_req_t req_i;
  logic     rsp_valid_o;
  logic     rsp_ready_i;
  lsq_rsp_t rsp_o;

  lsq_scoreboard sb;
  int unsigned   idle_cycles;
  logic [31:0]   addr_pool[4];
  int            sent;

  lsq_address_gen_store_forward_core i_dut (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_ready_o,
    .req_i,
    .rsp_valid_o,
    .rsp_ready_i,
    .rsp_o
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver stalls: runs of ready, runs of random stalls, and long stall runs.
  int unsigned stall_phase;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    case (stall_phase[9:8])
      2'd0:    rsp_ready_i <= 1'b1;
      2'd1:    rsp_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2:    rsp_ready_i <= (stall_phase[2:0] == 3'd0);
      default: rsp_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) sb.check_response(rsp_o);
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL lsq_address_gen_store_forward_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(lsq_req_t r);
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    sb.note_request(r);
    sent++;
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (n != 0) begin
      req_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic lsq_req_t make_write(logic [3:0] s, mem_op_e op, logic [31:0] addr,
                                          logic [31:0] data, bit brdy, bit srdy);
    lsq_req_t r;
    r = lsq_req_t'({$urandom, $urandom, $urandom, $urandom});
    r.kind = KIND_WRITE;
    r.slot = s;
    r.mem_op = op;
    r.tag = 6'($urandom);
    r.offset = $urandom;
    r.base_value = addr - r.offset;
    r.base_ready = brdy;
    r.store_value = data;
    r.store_ready = srdy;
    return r;
  endfunction

  function automatic lsq_req_t make_tick(logic [4:0] cnt, bit busy);
    lsq_req_t r;
    r = lsq_req_t'({$urandom, $urandom, $urandom, $urandom});
    r.kind = KIND_TICK;
    r.entry_count = cnt;
    r.bus_busy = busy;
    return r;
  endfunction

  initial begin
    lsq_req_t r;
    int       n;
    mem_op_e  op;
    bit       paused;
    sb = new();
    sent = 0;
    paused = 0;
    rst_ni <= 1'b0;
    req_valid_i <= 1'b0;
    req_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: three stores and every load type on two addresses, extreme values.
    send_request(make_write(4'd0, OP_SB, 32'h0, 32'hFFFF_FF80, 1, 1));
    send_request(make_write(4'd1, OP_LB, 32'h0, 32'h0, 1, 1));
    send_request(make_write(4'd2, OP_LBU, 32'h0, 32'h0, 1, 0));
    send_request(make_write(4'd3, OP_LH, 32'h0, 32'h0, 1, 1));
    send_request(make_write(4'd4, OP_SH, 32'hFFFF_FFFF, 32'h0000_8001, 1, 1));
    send_request(make_write(4'd5, OP_LHU, 32'hFFFF_FFFF, 32'h0, 1, 1));
    send_request(make_write(4'd6, OP_SW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1));
    send_request(make_write(4'd7, OP_LW, 32'hFFFF_FFFF, 32'h0, 1, 1));
    send_request(make_tick(5'd31, 1'b1));    // address only, bus busy
    send_request(make_tick(5'd0, 1'b0));     // empty queue
    for (int k = 0; k < 6; k++) send_request(make_tick(5'd16, 1'b0));
    // store data arrives late: the stalled load in slot 2 frees the walk
    send_request(make_write(4'd2, OP_LBU, 32'h0, 32'h0, 1, 1));
    send_request(make_write(4'd6, OP_SW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
    for (int k = 0; k < 6; k++) send_request(make_tick(5'd8, 1'b0));
    send_request(make_write(4'd15, OP_SW, 32'h1234, 32'h8765_4321, 1, 1));
    send_request(make_tick(5'd17, 1'b0));

    // Random: fill a queue prefix with loads and stores on four addresses, then tick.
    while (sent < NumItems) begin
      if (!paused && sent > NumItems / 2) begin
        paused = 1;
        req_valid_i <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge clk_i);
      end
      for (int a = 0; a < 4; a++) addr_pool[a] = $urandom;
      if ($urandom_range(0, 7) == 0) addr_pool[1] = addr_pool[0];
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
      for (int s = 0; s < n; s++) begin
        op = mem_op_e'($urandom_range(0, 7));
        send_request(make_write(s[3:0], op, addr_pool[$urandom_range(0, 3)], $urandom,
                                $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0));
        sender_gap();
      end
      for (int t = 0; t < n + 3; t++) begin
        if ($urandom_range(0, 9) == 0) begin
          r = lsq_req_t'({$urandom, $urandom, $urandom, $urandom});
        end else begin
          r = make_tick(5'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : n),
                        $urandom_range(0, 9) == 0);
        end
        send_request(r);
        sender_gap();
      end
    end
    req_valid_i <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("PASS lsq_address_gen_store_forward_core");
    end else begin
      $display("FAIL lsq_address_gen_store_forward_core");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lsq_pkg.sv
rtl/lsq_cell.sv
rtl/lsq_address_gen_store_forward_core.sv
tb/sv/lsq_address_gen_store_forward_core_tb.sv
